### hw/rtl/twcp_pkg.sv
// ----------------------------------------------------------------------------
// Textured wall column pixel: shared types and constants
// Item layouts, pixel kind and texture codes, register indexes and the
// payload structs that travel between the pipeline segments.
// ----------------------------------------------------------------------------
`default_nettype none

package twcp_pkg;

  localparam int IN_W      = 168;
  localparam int OUT_W     = 80;
  localparam int USER_W    = 2;
  localparam int CFG_IDX_W = 3;

  // multiplier and divider operand widths, fixed by the field widths
  localparam int PROD_W = 41;  // wall_distance (24u) times direction (16s)
  localparam int N_W    = 20;  // 2*row - screen_height + wall_height, signed
  localparam int DVD_W  = 27;  // n times tex_height/2, non-negative part
  localparam int DVS_W  = 16;  // wall_height

  typedef enum logic [1:0] {
    KIND_CEIL  = 2'd0,
    KIND_WALL  = 2'd1,
    KIND_FLOOR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [1:0] TEX_NORTH = 2'd0;
  localparam logic [1:0] TEX_SOUTH = 2'd1;
  localparam logic [1:0] TEX_WEST  = 2'd2;
  localparam logic [1:0] TEX_EAST  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING_COLOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COLOR   = 3'd5;

  typedef struct packed {
    logic [15:0] wall_height;
    logic [11:0] span_end;
    logic [11:0] span_start;
    logic [23:0] wall_distance;
    logic [23:0] eye_y;
    logic [23:0] eye_x;
    logic [15:0] dir_y;
    logic [15:0] dir_x;
    logic        hit_side;
    logic [10:0] row;
    logic [10:0] column;
  } pix_in_t;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [10:0] tex_width;
    logic [10:0] tex_height;
    logic [31:0] ceiling_color;
    logic [31:0] floor_color;
  } cfg_t;

  // pixel state that rides along the divider
  typedef struct packed {
    kind_t       kind;
    logic [31:0] fill;
    logic [1:0]  sel;
    logic [9:0]  tx;
    logic [21:0] addr;
    logic [10:0] ty_max;
    logic        neg;
    logic        sat;
  } pix_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] fill;
    logic [1:0]  sel;
    logic [9:0]  tx;
    logic [9:0]  ty;
    logic [21:0] addr;
  } pix_out_t;

endpackage

`default_nettype wire

### hw/rtl/twcp_front.sv
// ----------------------------------------------------------------------------
// Textured wall column pixel: front pipeline
// Three stages: classify and first multiplies, hit fraction and divider
// operand, texel column. Hands the texel row division to the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module twcp_front import twcp_pkg::*; #(
  parameter int FRAC_BITS    = 14,
  parameter int MAX_TEX_SIDE = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  pix_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pix_t             out_pix,
  output logic [DVD_W-1:0] out_dvd,
  output logic [DVS_W-1:0] out_dvs
);

  localparam int FW = 2 * FRAC_BITS;
  localparam int HW = (24 + FRAC_BITS > PROD_W) ? 24 + FRAC_BITS : PROD_W;
  localparam int QB = $clog2(MAX_TEX_SIDE);
  localparam int CW = (DVS_W + QB > DVD_W) ? DVS_W + QB : DVD_W;
  localparam logic [10:0] TEX_CAP = (MAX_TEX_SIDE > 2047) ? 11'd2047 : 11'(MAX_TEX_SIDE);

  logic en1, en2, en3;
  logic v1, v2;

  // ---------------- stage 1: classify, hit product, address product
  logic                     off_c, below_c, above_c, dzero_c;
  logic signed [15:0]       dcide_c, dcomp_c;
  logic [23:0]              eye_c;
  kind_t                    kind_c;
  logic [31:0]              fill_c;
  logic [1:0]               sel_c;
  logic [10:0]              tw_c, th_c;
  logic [15:0]              wh_c;
  logic signed [N_W-1:0]    n_c;
  logic signed [PROD_W-1:0] prod_c;
  logic [22:0]              ap_c;

  always_comb begin
    off_c   = {1'b0, in_data.row} >= cfg.screen_height;
    below_c = {1'b0, in_data.row} >= in_data.span_end;
    above_c = {1'b0, in_data.row} < in_data.span_start;
    dcide_c = in_data.hit_side ? $signed(in_data.dir_y) : $signed(in_data.dir_x);
    dcomp_c = in_data.hit_side ? $signed(in_data.dir_x) : $signed(in_data.dir_y);
    eye_c   = in_data.hit_side ? in_data.eye_x : in_data.eye_y;
    dzero_c = (dcide_c == 16'sd0);

    kind_c = KIND_WALL;
    fill_c = '0;
    if (off_c) begin
      kind_c = KIND_NONE;
    end else if (below_c) begin
      kind_c = KIND_FLOOR;
      fill_c = cfg.floor_color;
    end else if (above_c) begin
      kind_c = KIND_CEIL;
      fill_c = cfg.ceiling_color;
    end else if (dzero_c) begin
      kind_c = KIND_NONE;
    end

    if (kind_c != KIND_WALL) begin
      sel_c = TEX_NORTH;
    end else if (!in_data.hit_side) begin
      sel_c = in_data.dir_x[15] ? TEX_NORTH : TEX_SOUTH;
    end else begin
      sel_c = ($signed(in_data.dir_y) > 16'sd0) ? TEX_WEST : TEX_EAST;
    end

    if (cfg.tex_width == 11'd0) tw_c = 11'd1;
    else if (cfg.tex_width > TEX_CAP) tw_c = TEX_CAP;
    else tw_c = cfg.tex_width;

    if (cfg.tex_height < 11'd2) th_c = 11'd2;
    else if (cfg.tex_height > TEX_CAP) th_c = TEX_CAP;
    else th_c = cfg.tex_height;

    wh_c   = (in_data.wall_height == 16'd0) ? 16'd1 : in_data.wall_height;
    n_c    = $signed({8'd0, in_data.row, 1'b0}) - $signed({8'd0, cfg.screen_height})
           + $signed({4'd0, wh_c});
    prod_c = $signed({1'b0, in_data.wall_distance}) * dcomp_c;
    ap_c   = in_data.row * cfg.screen_width;
  end

  kind_t                    k1;
  logic [31:0]              fill1;
  logic [1:0]               sel1;
  logic [10:0]              tw1, thm1;
  logic [9:0]               half1;
  logic [15:0]              wh1;
  logic signed [N_W-1:0]    n1;
  logic signed [PROD_W-1:0] prod1;
  logic [23:0]              eye1;
  logic [22:0]              ap1;
  logic [10:0]              col1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      k1    <= kind_c;
      fill1 <= fill_c;
      sel1  <= sel_c;
      tw1   <= tw_c;
      thm1  <= th_c - 11'd1;
      half1 <= th_c[10:1];
      wh1   <= wh_c;
      n1    <= n_c;
      prod1 <= prod_c;
      eye1  <= eye_c;
      ap1   <= ap_c;
      col1  <= in_data.column;
    end
  end

  // ---------------- stage 2: hit fraction, divider dividend, address
  logic [HW-1:0] hit_c;
  logic [DVD_W-1:0] p_c;

  always_comb begin
    hit_c = HW'({eye1, {FRAC_BITS{1'b0}}}) + HW'(prod1);
    p_c   = n1[16:0] * half1;
  end

  kind_t       k2;
  logic [31:0] fill2;
  logic [1:0]  sel2;
  logic [10:0] tw2, thm2;
  logic [15:0] wh2;
  logic [FW-1:0] frac2;
  logic [DVD_W-1:0] p2;
  logic        neg2;
  logic [21:0] addr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      k2    <= k1;
      fill2 <= fill1;
      sel2  <= sel1;
      tw2   <= tw1;
      thm2  <= thm1;
      wh2   <= wh1;
      frac2 <= hit_c[FW-1:0];
      p2    <= p_c;
      neg2  <= n1[N_W-1];
      addr2 <= ap1[21:0] + {11'd0, col1};
    end
  end

  // ---------------- stage 3: texel column, saturation check
  logic [FW+10:0] tprod_c;
  logic [10:0]    tcol_c;
  logic [10:0]    txw_c;
  logic           sat_c;

  always_comb begin
    tprod_c = frac2 * tw2;
    tcol_c  = tprod_c[FW+10:FW];
    // mirror the column inside the texture
    txw_c   = tw2 - 11'd1 - tcol_c;
    sat_c   = CW'(p2) >= (CW'(wh2) << QB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
    if (en3) begin
      out_pix.kind   <= k2;
      out_pix.fill   <= fill2;
      out_pix.sel    <= sel2;
      out_pix.tx     <= (k2 == KIND_WALL) ? txw_c[9:0] : 10'd0;
      out_pix.addr   <= addr2;
      out_pix.ty_max <= thm2;
      out_pix.neg    <= neg2;
      out_pix.sat    <= sat_c;
      out_dvd        <= p2;
      out_dvs        <= wh2;
    end
  end

  // advance a stage when it is empty or the next one moves
  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

endmodule

`default_nettype wire

### hw/rtl/twcp_div.sv
// ----------------------------------------------------------------------------
// Textured wall column pixel: texel row divider
// Restoring division, one quotient bit per stage, most significant first.
// The pixel payload travels alongside the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module twcp_div import twcp_pkg::*; #(
  parameter int MAX_TEX_SIDE = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pix_t                              in_pix,
  input  logic [DVD_W-1:0]                  in_dvd,
  input  logic [DVS_W-1:0]                  in_dvs,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pix_t                              out_pix,
  output logic [$clog2(MAX_TEX_SIDE)-1:0]   out_quo
);

  localparam int QB = $clog2(MAX_TEX_SIDE);
  localparam int CW = (DVS_W + QB > DVD_W) ? DVS_W + QB : DVD_W;

  // index 0 is the input side, index k+1 the registers of stage k
  logic             a_v   [QB+1];
  pix_t             a_pix [QB+1];
  logic [CW-1:0]    a_rem [QB+1];
  logic [DVS_W-1:0] a_dvs [QB+1];
  logic [QB-1:0]    a_quo [QB+1];
  logic [QB:0]      en;

  assign a_v[0]   = in_valid;
  assign a_pix[0] = in_pix;
  assign a_rem[0] = CW'(in_dvd);
  assign a_dvs[0] = in_dvs;
  assign a_quo[0] = '0;
  assign en[QB]   = out_ready;
  assign in_ready = en[0];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int B = QB - 1 - k;
    logic [CW-1:0] trial;
    logic          ge;
    logic [CW-1:0] rem_next;
    logic [QB-1:0] quo_next;

    always_comb begin
      trial    = CW'(a_dvs[k]) << B;
      ge       = a_rem[k] >= trial;
      rem_next = ge ? a_rem[k] - trial : a_rem[k];
      quo_next = a_quo[k];
      quo_next[B] = ge;
    end

    assign en[k] = !a_v[k+1] || en[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v[k+1] <= 1'b0;
      end else if (en[k]) begin
        a_v[k+1] <= a_v[k];
      end
      if (en[k]) begin
        a_pix[k+1] <= a_pix[k];
        a_rem[k+1] <= rem_next;
        a_dvs[k+1] <= a_dvs[k];
        a_quo[k+1] <= quo_next;
      end
    end
  end

  assign out_valid = a_v[QB];
  assign out_pix   = a_pix[QB];
  assign out_quo   = a_quo[QB];

endmodule

`default_nettype wire

### hw/rtl/twcp_back.sv
// ----------------------------------------------------------------------------
// Textured wall column pixel: output stage
// Saturates the texel row into the texture and holds the result item
// until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module twcp_back import twcp_pkg::*; #(
  parameter int MAX_TEX_SIDE = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pix_t                            in_pix,
  input  logic [$clog2(MAX_TEX_SIDE)-1:0] in_quo,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pix_out_t                        out_pix
);

  localparam int QB = $clog2(MAX_TEX_SIDE);
  localparam int OW = (QB > 11) ? QB : 11;

  logic [OW-1:0] q_c, m_c, ty_c;
  logic          en;

  always_comb begin
    q_c = OW'(in_quo);
    m_c = OW'(in_pix.ty_max);
    // a negative numerator truncates to zero or below: clamp to the top row
    if (in_pix.kind != KIND_WALL || in_pix.neg) ty_c = '0;
    else if (in_pix.sat || q_c > m_c) ty_c = m_c;
    else ty_c = q_c;
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_pix.kind <= in_pix.kind;
      out_pix.fill <= in_pix.fill;
      out_pix.sel  <= in_pix.sel;
      out_pix.tx   <= in_pix.tx;
      out_pix.ty   <= ty_c[9:0];
      out_pix.addr <= in_pix.addr;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/textured_wall_column_pixel_top.sv
// ----------------------------------------------------------------------------
// Textured wall column pixel: top level
// Three front stages, one divider stage per texel row bit, one output
// register. Throughput is one item per cycle while the sink keeps
// m_tready high; the divider is fully pipelined.
// Reset is synchronous: pipeline emptied, registers back to 640x480, 64x64.
// ----------------------------------------------------------------------------
`default_nettype none

module textured_wall_column_pixel_top import twcp_pkg::*; #(
  parameter int FRAC_BITS    = 14,
  parameter int MAX_TEX_SIDE = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // column, row, hit_side, dir_x, dir_y, eye_x, eye_y, wall_distance,
  // span_start, span_end, wall_height, one pad bit
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // fill_color, texture_select, texel_x, texel_y, frame_address, 4 pad bits
  output logic [OUT_W-1:0]     m_tdata,
  // pixel_kind
  output logic [USER_W-1:0]    m_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int QB = $clog2(MAX_TEX_SIDE);

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 12'd640;
      cfg.screen_height <= 12'd480;
      cfg.tex_width     <= 11'd64;
      cfg.tex_height    <= 11'd64;
      cfg.ceiling_color <= '0;
      cfg.floor_color   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[11:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[11:0];
        REG_TEX_WIDTH:     cfg.tex_width     <= cfg_data[10:0];
        REG_TEX_HEIGHT:    cfg.tex_height    <= cfg_data[10:0];
        REG_CEILING_COLOR: cfg.ceiling_color <= cfg_data;
        REG_FLOOR_COLOR:   cfg.floor_color   <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  pix_in_t in_data;

  assign in_data.column        = s_tdata[10:0];
  assign in_data.row           = s_tdata[21:11];
  assign in_data.hit_side      = s_tdata[22];
  assign in_data.dir_x         = s_tdata[38:23];
  assign in_data.dir_y         = s_tdata[54:39];
  assign in_data.eye_x         = s_tdata[78:55];
  assign in_data.eye_y         = s_tdata[102:79];
  assign in_data.wall_distance = s_tdata[126:103];
  assign in_data.span_start    = s_tdata[138:127];
  assign in_data.span_end      = s_tdata[150:139];
  assign in_data.wall_height   = s_tdata[166:151];

  logic             f_valid, f_ready;
  pix_t             f_pix;
  logic [DVD_W-1:0] f_dvd;
  logic [DVS_W-1:0] f_dvs;
  logic             d_valid, d_ready;
  pix_t             d_pix;
  logic [QB-1:0]    d_quo;
  pix_out_t         o_pix;

  twcp_front #(
    .FRAC_BITS    (FRAC_BITS),
    .MAX_TEX_SIDE (MAX_TEX_SIDE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_pix   (f_pix),
    .out_dvd   (f_dvd),
    .out_dvs   (f_dvs)
  );

  twcp_div #(
    .MAX_TEX_SIDE (MAX_TEX_SIDE)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_pix    (f_pix),
    .in_dvd    (f_dvd),
    .in_dvs    (f_dvs),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_pix   (d_pix),
    .out_quo   (d_quo)
  );

  twcp_back #(
    .MAX_TEX_SIDE (MAX_TEX_SIDE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_pix    (d_pix),
    .in_quo    (d_quo),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pix   (o_pix)
  );

  assign m_tdata = {4'd0, o_pix.addr, o_pix.ty, o_pix.tx, o_pix.sel, o_pix.fill};
  assign m_tuser = o_pix.kind;

  // wall pixels carry no fill colour
  a_wall_no_fill: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_WALL) |-> (m_tdata[31:0] == 32'd0))
    else $error("wall item with nonzero fill colour");

  // non-wall pixels carry no texture select or texel coordinates
  a_flat_no_texel: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_WALL) |-> (m_tdata[53:32] == 22'd0))
    else $error("non-wall item with texel data");

  // an empty or draining output stage lets the whole pipeline advance
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while output stage can move");

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// Textured wall column pixel: testbench
// Streams screen pixels through the block and compares every output item,
// field by field, against a local predictor of the ceiling, wall and floor
// decision, texture choice, texel coordinates and frame address. Runs under
// several register settings, the extremes among them, with random idling on
// both stream sides in all but the final streaming test.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import twcp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC         = 14;
  localparam int TEX_SIDE_MAX = 1024;
  localparam int DRAIN_CYCLES = 20;

  // indexes past the register list; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_W-1:0]     m_tdata;
  logic [USER_W-1:0]    m_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // register copy used for prediction
  logic [11:0] scr_w     = 12'd640;
  logic [11:0] scr_h     = 12'd480;
  logic [10:0] tex_w     = 11'd64;
  logic [10:0] tex_h     = 11'd64;
  logic [31:0] ceil_col  = '0;
  logic [31:0] floor_col = '0;

  pix_out_t expected_pixels[$];
  int       err_count = 0;
  int       gap_pct;
  int       stall_pct;

  textured_wall_column_pixel_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic pix_out_t predict_pixel(input pix_in_t p);
    pix_out_t r;
    longint   dcide, dcomp, eye, prod, hit, frac, t, tw, th, wh, n, y;
    r = '0;
    if (p.row >= scr_h) begin
      r.kind = KIND_NONE;
    end else if (p.row >= p.span_end) begin
      r.kind = KIND_FLOOR;
      r.fill = floor_col;
    end else if (p.row < p.span_start) begin
      r.kind = KIND_CEIL;
      r.fill = ceil_col;
    end else begin
      dcide = p.hit_side ? longint'($signed(p.dir_y)) : longint'($signed(p.dir_x));
      if (dcide == 0) begin
        r.kind = KIND_NONE;
      end else begin
        tw = longint'(tex_w);
        if (tw < 1) tw = 1;
        if (tw > TEX_SIDE_MAX) tw = TEX_SIDE_MAX;
        th = longint'(tex_h);
        if (th < 2) th = 2;
        if (th > TEX_SIDE_MAX) th = TEX_SIDE_MAX;
        eye   = p.hit_side ? longint'(p.eye_x) : longint'(p.eye_y);
        dcomp = p.hit_side ? longint'($signed(p.dir_x)) : longint'($signed(p.dir_y));
        prod  = longint'(p.wall_distance) * dcomp;
        hit   = (eye << FRAC) + prod;
        // floor fraction of the hit point, also for negative positions
        frac  = hit & ((64'sd1 <<< (2 * FRAC)) - 1);
        t     = (frac * tw) >>> (2 * FRAC);
        r.kind = KIND_WALL;
        if (!p.hit_side) r.sel = ($signed(p.dir_x) < 0) ? TEX_NORTH : TEX_SOUTH;
        else             r.sel = ($signed(p.dir_y) > 0) ? TEX_WEST : TEX_EAST;
        r.tx = (t < tw) ? 10'(tw - 1 - t) : 10'd0;
        wh = (p.wall_height == 0) ? 1 : longint'(p.wall_height);
        n  = 2 * longint'(p.row) - longint'(scr_h) + wh;
        y  = n * (th / 2) / wh;
        if (y < 0) y = 0;
        if (y > th - 1) y = th - 1;
        r.ty = 10'(y);
      end
    end
    r.addr = 22'(longint'(p.row) * longint'(scr_w) + longint'(p.column));
    return r;
  endfunction

  function automatic pix_in_t rand_pixel();
    logic [166:0] bits;
    bits = 167'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return pix_in_t'(bits);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch: got %0h, want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic check_pixel();
    pix_out_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch("unexpected item", m_tdata[31:0], 0);
      return;
    end
    want = expected_pixels.pop_front();
    if (m_tuser != want.kind)        report_mismatch("pixel_kind", m_tuser, want.kind);
    if (m_tdata[31:0] != want.fill)  report_mismatch("fill_color", m_tdata[31:0], want.fill);
    if (m_tdata[33:32] != want.sel)  report_mismatch("texture_select", m_tdata[33:32], want.sel);
    if (m_tdata[43:34] != want.tx)   report_mismatch("texel_x", m_tdata[43:34], want.tx);
    if (m_tdata[53:44] != want.ty)   report_mismatch("texel_y", m_tdata[53:44], want.ty);
    if (m_tdata[75:54] != want.addr) report_mismatch("frame_address", m_tdata[75:54], want.addr);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_pixel();
  end

  // result side: random stall bursts
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // leaves tvalid high so that back-to-back items need no second assignment
  task automatic send_pixel(input pix_in_t p);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, p};
    do @(posedge clk); while (!s_tready);
    expected_pixels.push_back(predict_pixel(p));
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic drain_pipeline();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value,
                           input int width);
    logic [31:0] junk;
    logic [31:0] data;
    junk = $urandom;
    // garbage above the register width must be dropped
    data = (junk << width) | value;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SCREEN_WIDTH:  scr_w     = data[11:0];
      REG_SCREEN_HEIGHT: scr_h     = data[11:0];
      REG_TEX_WIDTH:     tex_w     = data[10:0];
      REG_TEX_HEIGHT:    tex_h     = data[10:0];
      REG_CEILING_COLOR: ceil_col  = data;
      REG_FLOOR_COLOR:   floor_col = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input int sw, input int sh, input int tw, input int th,
                            input logic [31:0] cc, input logic [31:0] fc);
    write_reg(REG_SCREEN_WIDTH, sw, 12);
    write_reg(REG_SCREEN_HEIGHT, sh, 12);
    write_reg(REG_TEX_WIDTH, tw, 11);
    write_reg(REG_TEX_HEIGHT, th, 11);
    write_reg(REG_CEILING_COLOR, cc, 32);
    write_reg(REG_FLOOR_COLOR, fc, 32);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_random_config();
    set_config($urandom_range(1, 2048), $urandom_range(1, 2048), $urandom_range(1, 1024),
               $urandom_range(2, 1024), $urandom, $urandom);
  endtask

  // mostly runs of rows down one ray's column, the rest loose random pixels
  task automatic send_columns(input int count);
    pix_in_t p;
    int      h, wh, top, bot, r0, len, k, sent;
    sent = 0;
    while (sent < count) begin
      p = rand_pixel();
      if ($urandom_range(0, 4) == 0) begin
        send_pixel(p);
        sent++;
      end else begin
        h = int'(scr_h);
        if ($urandom_range(0, 3) == 0) wh = $urandom_range(0, 65535);
        else                           wh = $urandom_range(1, 2 * h + 8);
        top = (h - wh) / 2;
        if (top < 0) top = 0;
        bot = (h + wh) / 2;
        if (bot > h) bot = h;
        p.wall_height = 16'(wh);
        p.span_start  = 12'(top);
        p.span_end    = 12'(bot);
        if ($urandom_range(0, 15) == 0) begin
          if (p.hit_side) p.dir_y = '0;
          else            p.dir_x = '0;
        end
        len = $urandom_range(4, 32);
        if ($urandom_range(0, 1) == 0) r0 = $urandom_range(0, (h > len) ? h - len : 0);
        else                           r0 = top - $urandom_range(0, len);
        if (r0 < 0) r0 = 0;
        for (k = 0; k < len && sent < count; k++) begin
          p.row = 11'(r0 + k);
          send_pixel(p);
          sent++;
        end
      end
    end
  endtask

  task automatic test_reset_directed();
    pix_in_t p;
    p = rand_pixel();
    p.span_start  = 12'd100;
    p.span_end    = 12'd380;
    p.wall_height = 16'd280;
    p.hit_side    = 1'b0;
    p.dir_x       = 16'hC000;
    p.row = 11'd0;   send_pixel(p);
    p.row = 11'd379; send_pixel(p);
    p.row = 11'd380; send_pixel(p);
    p.row = 11'd100; send_pixel(p);
    p.row = 11'd240; p.dir_x = 16'h4000; send_pixel(p);
    p.hit_side = 1'b1; p.dir_y = 16'h2000; send_pixel(p);
    p.dir_y = 16'hE000; send_pixel(p);
    // zero deciding direction: nothing written
    p.dir_y = '0; send_pixel(p);
    p.hit_side = 1'b0; p.dir_x = '0; send_pixel(p);
    p.dir_x = 16'h8000; p.dir_y = 16'h7FFF;
    p.eye_x = 24'hFFFFFF; p.eye_y = 24'hFFFFFF; p.wall_distance = 24'hFFFFFF;
    p.column = 11'd2047;
    send_pixel(p);
    p.hit_side = 1'b1; send_pixel(p);
    p.eye_x = '0; p.eye_y = '0; p.wall_distance = '0; p.column = '0;
    send_pixel(p);
    p.wall_height = '0; send_pixel(p);
    // off screen
    p.row = 11'd480;  send_pixel(p);
    p.row = 11'd2047; send_pixel(p);
    // crossed span: floor wins, then ceiling
    p.row = 11'd200; p.span_start = 12'd300; p.span_end = 12'd100; send_pixel(p);
    p.row = 11'd50; send_pixel(p);
    // texel row saturates high, then low
    p.span_start = '0; p.span_end = 12'hFFF; p.wall_height = 16'd1;
    p.row = 11'd479; send_pixel(p);
    p.row = 11'd0;   send_pixel(p);
    p.wall_height = 16'hFFFF; p.row = 11'd240; send_pixel(p);
    p.span_start = 12'hFFF; send_pixel(p);
    p.span_start = '0; p.span_end = '0; send_pixel(p);
  endtask

  task automatic test_register_extremes();
    drain_pipeline();
    set_config(2048, 2048, 1024, 1024, 32'hFFFF_FFFF, 32'h0000_0000);
    send_columns(100);
    drain_pipeline();
    // out of range: texture sides clamp, frame address wraps
    set_config(4095, 4095, 2047, 2047, 32'h0000_0000, 32'hFFFF_FFFF);
    send_columns(60);
    drain_pipeline();
    set_config(1, 1, 1, 2, 32'h5555_5555, 32'hAAAA_AAAA);
    send_columns(60);
    drain_pipeline();
    write_reg(REG_SPARE_LO, $urandom, 32);
    write_reg(REG_SPARE_HI, $urandom, 32);
    set_config(0, 480, 0, 1, 32'hA5A5_5A5A, 32'h0F0F_F0F0);
    send_columns(60);
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      drain_pipeline();
      set_random_config();
      send_columns(100);
    end
  endtask

  task automatic test_pause_and_resume();
    drain_pipeline();
    set_config(640, 480, 64, 64, $urandom, $urandom);
    repeat (5) begin
      send_columns(20);
      hold_until_drained();
    end
  endtask

  task automatic test_streaming_no_idle();
    drain_pipeline();
    gap_pct   = 0;
    stall_pct = 0;
    set_random_config();
    send_columns(150);
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= '0;
    gap_pct   = 25;
    stall_pct = 6;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_directed();
    test_register_extremes();
    test_random_settings();
    test_pause_and_resume();
    test_streaming_no_idle();

    drain_pipeline();
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
